/* design/cte_pkg.sv */
// ----------------------------------------------------------------------------
// cte_pkg
// shared types and constants for the columnar transposition encryptor
// ----------------------------------------------------------------------------
package cte_pkg;

    localparam int MAX_KEY_DEF = 32;
    localparam int LETTER_W    = 5;
    localparam int OP_W        = 2;

    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_KEY   = 2'd1,
        OP_MSG   = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_UPD,
        ST_KEY_FIN,
        ST_MSG_RD,
        ST_MSG_WR,
        ST_PAD_RD,
        ST_PAD_WR,
        ST_EMIT_RD,
        ST_EMIT_LOAD
    } state_t;

endpackage

/* design/columnar_transposition_encrypt_top.sv */
// ----------------------------------------------------------------------------
// columnar_transposition_encrypt_top
// columnar transposition encryptor: ranks key letters as they arrive, places
// message letters by column rank and emits each full or padded block
// ----------------------------------------------------------------------------
// channel  dir  tdata            tuser     tlast
// s_       in   letter [4:0]     op [1:0]  -
// m_       out  out_letter [4:0] -         block_end
//
// one word is taken only in idle; clear completes in idle, a key letter takes
// one read and one update per stored column, then a store; a message letter a
// rank read and slot write; end of message a read and a write per padded slot
// a block emits a read and a load per word, longer while m_tready is low
// aresetn (synchronous, active low) empties the key and the block
// s_tready stays low while a word is at work or a block is being emitted
// ----------------------------------------------------------------------------
module columnar_transposition_encrypt_top
    import cte_pkg::*;
#(
    parameter int MAX_KEY = MAX_KEY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] letter
    input  logic [1:0] s_tuser,   // [1:0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] out_letter
    output logic       m_tlast
);

    localparam int IDX_W = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int CNT_W = $clog2(MAX_KEY + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    key_len_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    rank_acc_reg;
    logic [LETTER_W-1:0] letter_reg;

    logic [LETTER_W-1:0] key_mem  [MAX_KEY];
    logic [IDX_W-1:0]    rank_mem [MAX_KEY];
    logic [LETTER_W-1:0] blk_mem  [MAX_KEY];

    logic [LETTER_W-1:0] key_rd_reg;
    logic [IDX_W-1:0]    rank_rd_reg;
    logic [LETTER_W-1:0] blk_rd_reg;

    logic                m_valid_reg;
    logic [LETTER_W-1:0] m_data_reg;
    logic                m_last_reg;

    op_t              op;
    logic             s_acc;
    logic             out_free;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] fill_inc;
    logic             cnt_last;
    logic             key_gt;
    logic             rank_ok;

    logic [IDX_W-1:0]    key_raddr, rank_raddr, blk_raddr;
    logic                key_we, rank_we, blk_we;
    logic [IDX_W-1:0]    key_waddr, rank_waddr, blk_waddr;
    logic [IDX_W-1:0]    rank_wdata;
    logic [LETTER_W-1:0] blk_wdata;

    assign op       = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign fill_inc = fill_reg + CNT_W'(1);
    assign cnt_last = (cnt_inc == key_len_reg);
    assign key_gt   = (key_rd_reg > letter_reg);
    assign rank_ok  = (int'(rank_rd_reg) < MAX_KEY);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (op)
                        OP_CLEAR: state_next = ST_IDLE;
                        OP_KEY: begin
                            if (int'(key_len_reg) >= MAX_KEY)
                                state_next = ST_IDLE;
                            else if (key_len_reg == '0)
                                state_next = ST_KEY_FIN;
                            else
                                state_next = ST_KEY_RD;
                        end
                        OP_MSG: begin
                            if (key_len_reg == '0 || fill_reg >= key_len_reg)
                                state_next = ST_IDLE;
                            else
                                state_next = ST_MSG_RD;
                        end
                        OP_END: begin
                            if (key_len_reg == '0 || fill_reg == '0)
                                state_next = ST_IDLE;
                            else if (fill_reg < key_len_reg)
                                state_next = ST_PAD_RD;
                            else
                                state_next = ST_EMIT_RD;
                        end
                    endcase
                end
            end
            ST_KEY_RD:  state_next = ST_KEY_UPD;
            ST_KEY_UPD: state_next = cnt_last ? ST_KEY_FIN : ST_KEY_RD;
            ST_KEY_FIN: state_next = ST_IDLE;
            ST_MSG_RD:  state_next = ST_MSG_WR;
            ST_MSG_WR:  state_next = (fill_inc == key_len_reg) ? ST_EMIT_RD : ST_IDLE;
            ST_PAD_RD:  state_next = ST_PAD_WR;
            ST_PAD_WR:  state_next = cnt_last ? ST_EMIT_RD : ST_PAD_RD;
            ST_EMIT_RD: state_next = ST_EMIT_LOAD;
            ST_EMIT_LOAD: begin
                if (out_free)
                    state_next = cnt_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        key_raddr  = cnt_reg[IDX_W-1:0];
        rank_raddr = cnt_reg[IDX_W-1:0];
        blk_raddr  = cnt_reg[IDX_W-1:0];
        key_we     = 1'b0;
        key_waddr  = key_len_reg[IDX_W-1:0];
        rank_we    = 1'b0;
        rank_waddr = cnt_reg[IDX_W-1:0];
        rank_wdata = rank_rd_reg + IDX_W'(1);
        blk_we     = 1'b0;
        blk_waddr  = rank_rd_reg;
        blk_wdata  = letter_reg;
        unique case (state_reg)
            ST_KEY_UPD: begin
                rank_we = key_gt;
            end
            ST_KEY_FIN: begin
                key_we     = 1'b1;
                rank_we    = 1'b1;
                rank_waddr = key_len_reg[IDX_W-1:0];
                rank_wdata = rank_acc_reg;
            end
            ST_MSG_RD: begin
                rank_raddr = fill_reg[IDX_W-1:0];
            end
            ST_MSG_WR: begin
                blk_we = rank_ok;
            end
            ST_PAD_WR: begin
                blk_we    = rank_ok;
                blk_wdata = PAD_LETTER;
            end
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (key_we)
            key_mem[key_waddr] <= letter_reg;
        if (rank_we)
            rank_mem[rank_waddr] <= rank_wdata;
        if (blk_we)
            blk_mem[blk_waddr] <= blk_wdata;
        key_rd_reg  <= key_mem[key_raddr];
        rank_rd_reg <= rank_mem[rank_raddr];
        blk_rd_reg  <= blk_mem[blk_raddr];
    end

    // sequencer and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            key_len_reg <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        letter_reg   <= s_tdata[LETTER_W-1:0];
                        rank_acc_reg <= '0;
                        cnt_reg      <= (op == OP_END && fill_reg < key_len_reg) ?
                                        fill_reg : '0;
                        if (op == OP_CLEAR) begin
                            key_len_reg <= '0;
                            fill_reg    <= '0;
                        end
                    end
                end
                ST_KEY_UPD: begin
                    if (!key_gt)
                        rank_acc_reg <= rank_acc_reg + IDX_W'(1);
                    cnt_reg <= cnt_inc;
                end
                ST_KEY_FIN: begin
                    key_len_reg <= key_len_reg + CNT_W'(1);
                    fill_reg    <= '0;
                end
                ST_MSG_WR: begin
                    fill_reg <= fill_inc;
                    cnt_reg  <= '0;
                end
                ST_PAD_WR: begin
                    cnt_reg <= cnt_last ? '0 : cnt_inc;
                end
                ST_EMIT_LOAD: begin
                    if (out_free) begin
                        cnt_reg <= cnt_inc;
                        if (cnt_last)
                            fill_reg <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT_LOAD && out_free) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= blk_rd_reg;
            m_last_reg  <= cnt_last;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - LETTER_W){1'b0}}, m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

/* bench/columnar_transposition_encrypt_check.sv */
// ----------------------------------------------------------------------------
// columnar_transposition_encrypt_check
// watches both stream channels of the encryptor, keeps its own copy of the key
// ranks and the block, predicts every ciphertext word and compares the words
// that come out in order, counting mismatches for the test top
// ----------------------------------------------------------------------------
module columnar_transposition_encrypt_check
    import cte_pkg::*;
#(
    parameter int MAX_KEY = MAX_KEY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] letter
    input  logic [1:0] s_tuser,   // [1:0] op
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [4:0] out_letter
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } cipher_word_t;

    logic [LETTER_W-1:0] key_letter [MAX_KEY];
    logic [5:0]          col_rank   [MAX_KEY];
    logic [LETTER_W-1:0] slot       [MAX_KEY];
    int                  key_len;
    int                  fill;
    cipher_word_t        cipher_q [$];

    task automatic emit_block();
        cipher_word_t w;
        for (int k = 0; k < key_len; k++) begin
            w.letter = slot[k];
            w.last   = (k == key_len - 1);
            cipher_q.push_back(w);
        end
        fill = 0;
    endtask

    task automatic encrypt_word(input op_t op, input logic [LETTER_W-1:0] letter);
        int r;
        r = 0;
        case (op)
            OP_CLEAR: begin
                key_len = 0;
                fill    = 0;
            end
            OP_KEY: begin
                if (key_len < MAX_KEY) begin
                    for (int i = 0; i < key_len; i++) begin
                        if (key_letter[i] <= letter)
                            r++;
                        else
                            col_rank[i] = col_rank[i] + 1;
                    end
                    key_letter[key_len] = letter;
                    col_rank[key_len]   = r[5:0];
                    key_len++;
                    fill = 0;
                end
            end
            OP_MSG: begin
                if (key_len != 0 && fill < key_len) begin
                    slot[col_rank[fill]] = letter;
                    fill++;
                    if (fill == key_len)
                        emit_block();
                end
            end
            default: begin
                if (key_len != 0 && fill != 0) begin
                    for (int i = fill; i < key_len; i++)
                        slot[col_rank[i]] = PAD_LETTER;
                    emit_block();
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        cipher_word_t exp_w;
        if (!aresetn) begin
            key_len    = 0;
            fill       = 0;
            fail_count = 0;
            cipher_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                encrypt_word(op_t'(s_tuser), s_tdata[LETTER_W-1:0]);
            if (m_tvalid && m_tready) begin
                if (cipher_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word: expected none, actual letter %0d last %0b",
                             $realtime, m_tdata[LETTER_W-1:0], m_tlast);
                end else begin
                    exp_w = cipher_q.pop_front();
                    if (m_tdata[LETTER_W-1:0] !== exp_w.letter) begin
                        fail_count++;
                        $display("%0t: letter mismatch: expected %0d, actual %0d",
                                 $realtime, exp_w.letter, m_tdata[LETTER_W-1:0]);
                    end
                    if (m_tlast !== exp_w.last) begin
                        fail_count++;
                        $display("%0t: block end mismatch: expected %0b, actual %0b",
                                 $realtime, exp_w.last, m_tlast);
                    end
                end
            end
        end
        pending = cipher_q.size();
    end

endmodule

/* bench/columnar_transposition_encrypt_top_test.sv */
// ----------------------------------------------------------------------------
// columnar_transposition_encrypt_top_test
// drives key, message and end words into the encryptor with random gaps on
// both channels: a directed opening, then random keys and messages with some
// noise; a separate checker predicts and compares the ciphertext
// ----------------------------------------------------------------------------
module columnar_transposition_encrypt_top_test
    import cte_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 330;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // [4:0] letter
    logic [1:0] s_tuser  = 2'd0;   // [1:0] op
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [4:0] out_letter
    logic       m_tlast;

    int fail_count;
    int pending;
    int words_sent = 0;
    int snd_idle   = 7;
    int rcv_stall  = 45;
    int idle_cycles = 0;

    columnar_transposition_encrypt_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    columnar_transposition_encrypt_check check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= rcv_stall);

    // nothing accepted on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** columnar_transposition_encrypt_top: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_word(input op_t op, input logic [LETTER_W-1:0] letter);
        if (words_sent < RANDOM_WORDS / 3) begin
            snd_idle  = 7;
            rcv_stall = 45;
        end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
            snd_idle  = 45;
            rcv_stall = 7;
        end else begin
            snd_idle  = 0;
            rcv_stall = 0;
        end
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, letter};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
    endtask

    function automatic logic [LETTER_W-1:0] rand_letter();
        if ($urandom_range(0, 4) == 0)
            return LETTER_W'($urandom_range(0, 31));
        return LETTER_W'($urandom_range(0, 25));
    endfunction

    task automatic load_key(input int len);
        for (int i = 0; i < len; i++)
            send_word(OP_KEY, rand_letter());
    endtask

    task automatic send_message(input int len, input bit close);
        for (int i = 0; i < len; i++)
            send_word(OP_MSG, rand_letter());
        if (close)
            send_word(OP_END, rand_letter());
    endtask

    initial begin
        int len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no key yet: ignored
        send_word(OP_MSG, 5'd4);
        send_word(OP_END, 5'd0);
        // single column key
        send_word(OP_KEY, 5'd1);
        send_word(OP_MSG, 5'd0);
        send_word(OP_MSG, 5'd31);
        send_word(OP_END, 5'd31);
        // ties and letters above z
        send_word(OP_CLEAR, 5'd31);
        send_word(OP_KEY, 5'd31);
        send_word(OP_KEY, 5'd0);
        send_word(OP_KEY, 5'd25);
        send_word(OP_KEY, 5'd0);
        send_word(OP_MSG, 5'd1);
        send_word(OP_MSG, 5'd2);
        // key letter drops the partial block
        send_word(OP_KEY, 5'd25);
        send_word(OP_MSG, 5'd3);
        send_word(OP_END, 5'd7);
        for (int i = 0; i < 5; i++)
            send_word(OP_MSG, LETTER_W'(26 + i));
        send_word(OP_END, 5'd0);

        // overfilled key first
        send_word(OP_CLEAR, 5'd0);
        load_key(34);
        send_message(40, 1'b1);

        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 15) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_word(op_t'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)));
            end else begin
                if ($urandom_range(0, 1) == 1)
                    send_word(OP_CLEAR, rand_letter());
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(30, 35);
                else
                    len = $urandom_range(1, 8);
                load_key(len);
                if (len > 8)
                    len = 8;
                send_message($urandom_range(0, 3 * len + 2), ($urandom_range(0, 9) < 7));
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("** columnar_transposition_encrypt_top: PASSED **");
        else
            $display("** columnar_transposition_encrypt_top: FAILED **");
        $finish;
    end

endmodule
